// ===== rtl/core/sld_pkg.sv =====
// shared types and constants of the scan lock target detector
package sld_pkg;

  // default sizes
  localparam int NUM_STEPS_DEF = 64;
  localparam int DIST_BITS_DEF = 16;

  // fixed field widths
  localparam int IDX_W       = 6;
  localparam int VAL_W       = 16;
  localparam int CFG_W       = 7;
  localparam int MIN_LOCK_W  = 7;
  localparam int MAX_BREAK_W = 6;
  localparam int MISS_W      = 7;
  localparam int CMD_W       = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // configuration register indexes
  localparam logic CFG_MIN_LOCK  = 1'b0;
  localparam logic CFG_MAX_BREAK = 1'b1;

  // configuration reset values
  localparam logic [MIN_LOCK_W-1:0]  MIN_LOCK_RST  = 7'd1;
  localparam logic [MAX_BREAK_W-1:0] MAX_BREAK_RST = 6'd0;

  // item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_MEAS  = 2'd2
  } cmd_e;

  // request held while the baseline read completes
  typedef struct packed {
    cmd_e             cmd;
    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic [VAL_W-1:0] distance;
    logic             ok;
  } meas_t;

  // result of one request
  typedef struct packed {
    logic             locked;
    logic [IDX_W-1:0] tidx;
    logic             found;
  } result_t;

endpackage

// ===== rtl/core/sld_ram.sv =====
// generic single write port ram with registered read
module sld_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sld_lock.sv =====
// lock tracker: contact test, lock span and midpoint
module sld_lock #(
  parameter int DIST_BITS = sld_pkg::DIST_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  sld_pkg::meas_t                      meas_i,
  input  logic [DIST_BITS-1:0]                base_i,
  input  logic [sld_pkg::MIN_LOCK_W-1:0]      min_lock_i,
  input  logic [sld_pkg::MAX_BREAK_W-1:0]     max_break_i,
  output sld_pkg::result_t                    res_o
);
  import sld_pkg::*;

  logic              active_q, active_d;
  logic [IDX_W-1:0]  first_q, first_d;
  logic [IDX_W-1:0]  last_q, last_d;
  logic [MISS_W-1:0] miss_q, miss_d;

  logic [DIST_BITS-1:0] base_eff;
  logic                 valid_meas;
  logic                 hit;
  logic [IDX_W-1:0]     first_new;
  logic [IDX_W-1:0]     diff;
  logic [MIN_LOCK_W-1:0] span;
  logic [MISS_W-1:0]    miss_inc;

  // contact test against the step baseline
  assign base_eff   = meas_i.in_range ? base_i : '0;
  assign valid_meas = (base_eff != '0) && meas_i.ok;
  assign hit        = meas_i.distance[DIST_BITS-1:0] < base_eff;

  // span and midpoint of the lock including this step
  assign first_new = active_q ? first_q : meas_i.idx;
  assign diff      = meas_i.idx - first_new;
  assign span      = {1'b0, diff} + MIN_LOCK_W'(1);
  assign miss_inc  = miss_q + MISS_W'(1);

  // next lock state and result
  always_comb begin
    active_d   = active_q;
    first_d    = first_q;
    last_d     = last_q;
    miss_d     = miss_q;
    res_o.found = 1'b0;
    res_o.tidx  = '0;
    unique case (meas_i.cmd)
      CMD_START: begin
        active_d = 1'b0;
        first_d  = '0;
        last_d   = '0;
        miss_d   = '0;
      end
      CMD_MEAS: begin
        if (valid_meas) begin
          if (hit) begin
            active_d = 1'b1;
            first_d  = first_new;
            last_d   = meas_i.idx;
            miss_d   = '0;
            if (span >= min_lock_i) begin
              res_o.found = 1'b1;
              res_o.tidx  = meas_i.idx - (diff >> 1);
            end
          end else if (active_q) begin
            miss_d = miss_inc;
            if (miss_inc > {1'b0, max_break_i}) begin
              active_d = 1'b0;
              first_d  = '0;
              last_d   = '0;
              miss_d   = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res_o.locked = active_d;
  end

  // lock state registers, updated as each request leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      first_q  <= '0;
      last_q   <= '0;
      miss_q   <= '0;
    end else if (adv_i) begin
      active_q <= active_d;
      first_q  <= first_d;
      last_q   <= last_d;
      miss_q   <= miss_d;
    end
  end

endmodule

// ===== rtl/core/scan_lock_target_detector_top.sv =====
// top level of the scan lock target detector
// a request passes the request register and then the output register before
// its result is offered, and waits in the request register while the output stalls
// throughput: one request per cycle while the output does not stall, the baseline
// ram is read once per request and the lock update uses the held read data
// reset clears the lock state and pipeline valid flags, and resets the configuration registers
// the baseline ram is not cleared and holds garbage until loaded
module scan_lock_target_detector_top #(
  parameter int NUM_STEPS = sld_pkg::NUM_STEPS_DEF,
  parameter int DIST_BITS = sld_pkg::DIST_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // slave side
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // step_index[5:0], baseline_value[21:6], distance[37:22], measure_ok[38], zero pad
  input  logic [sld_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // cmd[1:0]
  input  logic [sld_pkg::CMD_W-1:0]          s_axis_tuser,
  // master side
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // target_found[0], target_index[6:1], locked[7]
  output logic [sld_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [sld_pkg::CFG_W-1:0]          cfg_data_i
);
  import sld_pkg::*;

  localparam int AW = $clog2(NUM_STEPS);

  logic [MIN_LOCK_W-1:0]  min_lock_q;
  logic [MAX_BREAK_W-1:0] max_break_q;

  logic                 s_accept;
  logic                 s1_valid_q;
  meas_t                s1_meas_q;
  meas_t                in_meas;
  logic                 s1_adv;
  logic [IDX_W-1:0]     in_idx;
  logic [VAL_W-1:0]     in_bval;
  logic                 in_range;
  logic [AW-1:0]        ram_addr;
  logic                 ram_we;
  logic [DIST_BITS-1:0] ram_rdata;
  result_t              res;
  logic                 m_valid_q;
  result_t              m_res_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_lock_q  <= MIN_LOCK_RST;
      max_break_q <= MAX_BREAK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_LOCK:  min_lock_q  <= cfg_data_i;
        CFG_MAX_BREAK: max_break_q <= cfg_data_i[MAX_BREAK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // request unpack
  assign in_idx   = s_axis_tdata[5:0];
  assign in_bval  = s_axis_tdata[21:6];
  assign in_range = 32'(in_idx) < 32'(NUM_STEPS);
  assign ram_addr = AW'(in_idx);

  assign in_meas.cmd      = cmd_e'(s_axis_tuser);
  assign in_meas.idx      = in_idx;
  assign in_meas.in_range = in_range;
  assign in_meas.distance = s_axis_tdata[37:22];
  assign in_meas.ok       = s_axis_tdata[38];

  // flow control through the two stages
  assign s1_adv        = s1_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign ram_we        = s_accept && (in_meas.cmd == CMD_LOAD) && in_range;

  // baseline table
  sld_ram #(
    .WIDTH(DIST_BITS),
    .DEPTH(NUM_STEPS)
  ) u_base_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_addr),
    .wdata_i(in_bval[DIST_BITS-1:0]),
    .re_i   (s_accept),
    .raddr_i(ram_addr),
    .rdata_o(ram_rdata)
  );

  // request waiting for its baseline read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_meas_q <= in_meas;
    end
  end

  // lock update
  sld_lock #(
    .DIST_BITS(DIST_BITS)
  ) u_lock (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (s1_adv),
    .meas_i     (s1_meas_q),
    .base_i     (ram_rdata),
    .min_lock_i (min_lock_q),
    .max_break_i(max_break_q),
    .res_o      (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_adv) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_res_q;

endmodule

// ===== rtl/core/sld_checker.sv =====
// port level checks of the scan lock target detector and their binding
module sld_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sld_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // no result shown right after a sampled reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  // a stalled result stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a reported target lies inside an active lock
  a_found_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[7])
    else $error("target reported without lock");

  // no target means a zero index
  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[6:1] == 6'd0)
    else $error("target index set without target");

endmodule

bind scan_lock_target_detector_top sld_checker u_sld_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ===== test/tb_scan_lock_target_detector_top.sv =====
// testbench of the scan lock target detector: directed and random streams checked by a predictor
module tb_scan_lock_target_detector_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sld_pkg::*;

  // the command code that the block ignores
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int NUM_ITEMS = 1800;
  localparam int PRINT_LIMIT = 100;

  // predictor of the lock tracking and store of expected results
  class lock_scoreboard;
    logic [VAL_W-1:0]       base_tbl [NUM_STEPS_DEF];
    bit                     lock_on;
    logic [IDX_W-1:0]       first_idx;
    logic [IDX_W-1:0]       last_idx;
    logic [MISS_W-1:0]      misses;
    logic [MIN_LOCK_W-1:0]  min_lock = MIN_LOCK_RST;
    logic [MAX_BREAK_W-1:0] max_break = MAX_BREAK_RST;
    result_t                expected_results [$];
    int                     mismatches;

    function void drop_lock();
      lock_on   = 1'b0;
      first_idx = '0;
      last_idx  = '0;
      misses    = '0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
      mismatches++;
    endtask

    // work out the result of one accepted request
    function void note_request(input logic [CMD_W-1:0] cmd, input logic [IN_TDATA_W-1:0] data);
      logic [IDX_W-1:0] idx;
      logic [VAL_W-1:0] bval;
      logic [VAL_W-1:0] distance;
      logic             ok;
      logic [VAL_W-1:0] base;
      logic [IDX_W-1:0] span;
      result_t          res;
      idx      = data[5:0];
      bval     = data[21:6];
      distance = data[37:22];
      ok       = data[38];
      res      = '0;
      case (cmd)
        CMD_LOAD: begin
          base_tbl[idx] = bval;
        end
        CMD_START: begin
          drop_lock();
        end
        CMD_MEAS: begin
          base = base_tbl[idx];
          if (base != '0 && ok) begin
            if (distance < base) begin
              if (!lock_on) begin
                lock_on   = 1'b1;
                first_idx = idx;
              end
              last_idx = idx;
              misses   = '0;
              // span wraps modulo the step count on a falling index
              span = last_idx - first_idx;
              if ({1'b0, span} + 7'd1 >= min_lock) begin
                res.found = 1'b1;
                res.tidx  = last_idx - (span >> 1);
              end
            end else if (lock_on) begin
              misses = misses + 7'd1;
              if (misses > {1'b0, max_break}) drop_lock();
            end
          end
        end
        default: begin
        end
      endcase
      res.locked = lock_on;
      expected_results.push_back(res);
    endfunction

    // compare one accepted result with the oldest expectation
    task check_result(input logic [OUT_TDATA_W-1:0] data);
      result_t got;
      result_t want;
      got = result_t'(data);
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", data));
      end else begin
        want = expected_results.pop_front();
        if (got.found !== want.found)
          report_mismatch($sformatf("target_found %b, expected %b", got.found, want.found));
        if (got.tidx !== want.tidx)
          report_mismatch($sformatf("target_index %0d, expected %0d", got.tidx, want.tidx));
        if (got.locked !== want.locked)
          report_mismatch($sformatf("locked %b, expected %b", got.locked, want.locked));
      end
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]       s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i = 1'b0;
  logic                   cfg_idx_i = CFG_MIN_LOCK;
  logic [CFG_W-1:0]       cfg_data_i = '0;

  lock_scoreboard sb = new;
  bit             no_idle;
  int             sent_items;

  scan_lock_target_detector_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // watch both handshakes
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tuser, s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // receiver with random stalls
  initial begin
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk_i);
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // send one request, returns at the falling edge after it was taken
  task send_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                    input logic [VAL_W-1:0] bval, input logic [VAL_W-1:0] distance,
                    input logic ok);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, ok, distance, bval, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
    @(negedge clk_i);
  endtask

  // measurement that is a contact or a miss against the stored baseline
  task measure_step(input logic [IDX_W-1:0] idx, input bit hit, input logic ok);
    logic [VAL_W-1:0] base;
    logic [VAL_W-1:0] distance;
    base = sb.base_tbl[idx];
    if (base == '0) distance = VAL_W'($urandom_range(0, 65535));
    else if (hit) distance = VAL_W'($urandom_range(0, base - 1));
    else distance = VAL_W'($urandom_range(base, 65535));
    send_request(CMD_MEAS, idx, VAL_W'($urandom_range(0, 65535)), distance, ok);
  endtask

  function logic [VAL_W-1:0] pick_baseline();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 2) return '0;
    if (roll == 2) return 16'd1;
    if (roll == 3) return 16'hFFFF;
    return VAL_W'($urandom_range(1, 65535));
  endfunction

  // stray request in the middle of a sweep
  task send_noise();
    case ($urandom_range(0, 4))
      0: send_request(CMD_UNUSED, IDX_W'($urandom_range(0, 63)), VAL_W'($urandom_range(0, 65535)),
                      VAL_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      1: send_request(CMD_LOAD, IDX_W'($urandom_range(0, 63)), pick_baseline(),
                      VAL_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      2: send_request(CMD_START, IDX_W'($urandom_range(0, 63)), VAL_W'($urandom_range(0, 65535)),
                      VAL_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      3: send_request(CMD_MEAS, IDX_W'($urandom_range(0, 63)), VAL_W'($urandom_range(0, 65535)),
                      VAL_W'($urandom_range(0, 65535)), 1'b0);
      default: measure_step(IDX_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), 1'b1);
    endcase
  endtask

  // hold off until every expected result came back, with a limit
  task wait_results_done(input int limit);
    int waited;
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < limit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (6) @(negedge clk_i);
  endtask

  // registers are written only with the block idle
  task set_config(input logic [MIN_LOCK_W-1:0] minl, input logic [MAX_BREAK_W-1:0] maxb);
    wait_results_done(2000);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MIN_LOCK;
    cfg_data_i <= minl;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_MAX_BREAK;
    cfg_data_i <= {1'b0, maxb};
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.min_lock  = minl;
    sb.max_break = maxb;
  endtask

  initial begin
    logic [MIN_LOCK_W-1:0]  minl;
    logic [MAX_BREAK_W-1:0] maxb;
    logic [IDX_W-1:0]       first_step;
    int                     phase;
    int                     sweeps;
    int                     len;
    int                     hit_pct;

    no_idle = 1'b0;
    sent_items = 0;
    sb.drop_lock();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed: field extremes, skipped steps, failed readings, wrap of the index
    send_request(CMD_UNUSED, 6'd63, 16'hFFFF, 16'hFFFF, 1'b1);
    send_request(CMD_LOAD, 6'd0, 16'hFFFF, 16'd0, 1'b0);
    send_request(CMD_LOAD, 6'd63, 16'd1, 16'hFFFF, 1'b1);
    send_request(CMD_LOAD, 6'd1, 16'd0, 16'd0, 1'b0);
    send_request(CMD_LOAD, 6'd2, 16'd1000, 16'd0, 1'b0);
    send_request(CMD_LOAD, 6'd3, 16'd1000, 16'd0, 1'b0);
    send_request(CMD_START, 6'd0, 16'd0, 16'd0, 1'b0);
    send_request(CMD_MEAS, 6'd0, 16'd0, 16'd0, 1'b1);
    send_request(CMD_MEAS, 6'd1, 16'd0, 16'd0, 1'b1);
    send_request(CMD_MEAS, 6'd2, 16'd0, 16'hFFFF, 1'b0);
    send_request(CMD_MEAS, 6'd2, 16'd0, 16'd999, 1'b1);
    send_request(CMD_MEAS, 6'd3, 16'd0, 16'd1000, 1'b1);
    send_request(CMD_MEAS, 6'd63, 16'd0, 16'd0, 1'b1);
    send_request(CMD_MEAS, 6'd0, 16'd0, 16'hFFFE, 1'b1);
    send_request(CMD_LOAD, 6'd3, 16'd1, 16'd0, 1'b1);
    send_request(CMD_UNUSED, 6'd0, 16'd0, 16'd0, 1'b0);
    send_request(CMD_MEAS, 6'd2, 16'd0, 16'd0, 1'b1);
    send_request(CMD_START, 6'd63, 16'hFFFF, 16'hFFFF, 1'b1);
    send_request(CMD_MEAS, 6'd63, 16'd0, 16'd1, 1'b1);

    // random phases, each with its own register setting
    phase = 0;
    while (sent_items < NUM_ITEMS) begin
      case (phase)
        0: begin minl = 7'd0;   maxb = 6'd0;  end
        1: begin minl = 7'd64;  maxb = 6'd63; end
        2: begin minl = 7'd127; maxb = 6'd3;  end
        3: begin minl = 7'd1;   maxb = 6'd0;  end
        4: begin minl = 7'd2;   maxb = 6'd1;  end
        default: begin
          minl = MIN_LOCK_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                          : $urandom_range(0, 20));
          maxb = MAX_BREAK_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                           : $urandom_range(0, 3));
        end
      endcase
      set_config(minl, maxb);
      no_idle = ($urandom_range(0, 3) == 0);

      // the whole table is loaded in the first phase so no unwritten entry is read
      if (phase == 0 || $urandom_range(0, 2) == 0) begin
        for (int i = 0; i < NUM_STEPS_DEF; i++) begin
          send_request(CMD_LOAD, IDX_W'(i), pick_baseline(), VAL_W'($urandom_range(0, 65535)),
                       1'($urandom_range(0, 1)));
        end
      end

      sweeps = $urandom_range(1, 3);
      for (int s = 0; s < sweeps; s++) begin
        case ($urandom_range(0, 2))
          0: hit_pct = 95;
          1: hit_pct = 75;
          default: hit_pct = 40;
        endcase
        if ($urandom_range(0, 9) != 0) begin
          send_request(CMD_START, IDX_W'($urandom_range(0, 63)), VAL_W'($urandom_range(0, 65535)),
                       VAL_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        end
        first_step = ($urandom_range(0, 2) == 0) ? IDX_W'($urandom_range(0, 63)) : 6'd0;
        len = ($urandom_range(0, 2) == 0) ? 64 : $urandom_range(8, 64);
        // index rises and may wrap past the last step
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 99) < 8) send_noise();
          measure_step(IDX_W'(32'(first_step) + k), $urandom_range(0, 99) < hit_pct,
                       $urandom_range(0, 19) != 0);
        end
      end
      phase++;
    end

    // wind down and judge
    wait_results_done(5000);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
